// ===== hw/rtl/wbas_pkg.sv =====
// Shared types, constants and helpers for the Warming-Beam advection step.
package wbas_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int FRAC_BITS    = 14;
  localparam int CN_W         = 16;
  localparam int COEF_W       = 33;
  localparam int IDX_W        = 11;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam int GRID_MAX_DEF = 1024;
  localparam int JQ_DEPTH_DEF = 4;
  localparam int RQ_DEPTH_DEF = 8;

  typedef logic [CN_W-1:0]               cn_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [ADDR_W-3:0]             reg_idx_t;

  // register map (word index)
  localparam reg_idx_t REG_COURANT = reg_idx_t'(0);

  localparam cn_t   CN_RESET   = cn_t'(8192);
  localparam coef_t COEF_RESET = coef_t'(64'sd67108864);

  // fixed grid indices of the wrap results
  localparam idx_t IDX_WRAP = idx_t'(1);
  localparam idx_t IDX_ZERO = idx_t'(0);

  typedef struct packed {
    sample_t sample;
    logic    row_end;
  } in_item_t;

  typedef struct packed {
    sample_t new_value;
    idx_t    point_index;
    logic    row_done;
    logic    saturated;
  } out_item_t;

  // work one accepted point leaves for the back end
  typedef enum logic [1:0] {
    JOB_MAIN,       // interior point: one update
    JOB_MAIN_WRAP,  // last point: update, wrap for index 1, copy for index 0
    JOB_WRAP        // two-point row: wrap for index 1, copy for index 0
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    sample_t   cur;
    sample_t   prev;
    sample_t   prev2;
    sample_t   first;
    sample_t   second;
    idx_t      idx;
  } job_t;

  typedef enum logic [1:0] {
    SEQ_FIRST,
    SEQ_SECOND,
    SEQ_THIRD
  } seq_state_t;

  // c*(1-c) in Q28: C*2^14 - C*C
  function automatic coef_t courant_coef(input cn_t c);
    logic [2*CN_W-1:0] sq;
    logic [COEF_W:0]   t;
    sq = c * c;
    t  = (COEF_W+1)'({c, {FRAC_BITS{1'b0}}}) - (COEF_W+1)'(sq);
    return coef_t'(t);
  endfunction

endpackage

// ===== hw/rtl/warming_beam_advection_step.sv =====
// Top level of the Warming-Beam advection step: config, front end, job queue, back end.
// Throughput: one result per cycle while jobs wait and the result queue has room.
//   An interior point gives one result, so points stream one per cycle; the last point
//   of a row of three or more gives three, which the back end issues in turn from the
//   job queue while the front keeps taking points.
// Reset (synchronous, rst_n low): row restarts at index 0, queues empty, courant = 0.5.
module warming_beam_advection_step #(
  parameter int GRID_MAX = wbas_pkg::GRID_MAX_DEF,
  parameter int JQ_DEPTH = wbas_pkg::JQ_DEPTH_DEF,
  parameter int RQ_DEPTH = wbas_pkg::RQ_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          push,
  output logic                          full,
  input  wbas_pkg::in_item_t            in_data,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output wbas_pkg::out_item_t           out_data,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wbas_pkg::ADDR_W-1:0]   paddr,
  input  logic [wbas_pkg::DATA_W-1:0]   pwdata,
  output logic [wbas_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // Courant number and precomputed c*(1-c) coefficient. The user must see they are
  // written only while the block is idle, so the pipeline never sees a mix; unchecked.
  // ---------------------------------------------------------------------------
  wbas_pkg::cn_t   courant_r, courant_nxt;
  wbas_pkg::coef_t coef_r, coef_nxt;
  logic            cfg_wr;
  logic            cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[wbas_pkg::ADDR_W-1:2] == wbas_pkg::REG_COURANT);
  assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;

  always_comb begin
    courant_nxt = courant_r;
    coef_nxt    = coef_r;
    if (cfg_wr) begin
      courant_nxt = pwdata[wbas_pkg::CN_W-1:0];
      coef_nxt    = wbas_pkg::courant_coef(pwdata[wbas_pkg::CN_W-1:0]);
    end
    prdata = cfg_hit ? wbas_pkg::DATA_W'(courant_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      courant_r <= wbas_pkg::CN_RESET;
      coef_r    <= wbas_pkg::COEF_RESET;
    end else begin
      courant_r <= courant_nxt;
      coef_r    <= coef_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: keeps the three-point window and row position, turns each
  // point into zero or one job (a job carries up to three updates).
  // ---------------------------------------------------------------------------
  logic                          accept;
  logic                          jq_push, jq_pop, jq_empty, jq_full;
  logic [$clog2(JQ_DEPTH+1)-1:0] jq_count;
  wbas_pkg::job_t                job_in, job_head;

  // points are taken whenever the job queue has room
  assign accept = push & ~jq_full;
  assign full   = jq_full;

  wbas_front #(
    .GRID_MAX (GRID_MAX)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .jq_push (jq_push),
    .job     (job_in)
  );

  wbas_fifo #(
    .T     (wbas_pkg::job_t),
    .DEPTH (JQ_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (jq_push),
    .wr_data (job_in),
    .rd_en   (jq_pop),
    .rd_data (job_head),
    .empty   (jq_empty),
    .full    (jq_full),
    .count   (jq_count)
  );

  // ---------------------------------------------------------------------------
  // Back end: expands jobs into updates, one per cycle when credit allows, through a
  // three-stage pipeline. Issue is credit-checked against the result queue so that the
  // pipeline never stalls and never overruns the queue.
  // ---------------------------------------------------------------------------
  logic                          res_push;
  wbas_pkg::out_item_t           res_item;
  logic [$clog2(RQ_DEPTH+1)-1:0] rq_count;
  logic                          rq_full;

  wbas_back #(
    .RQ_DEPTH (RQ_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_head),
    .job_empty (jq_empty),
    .job_pop   (jq_pop),
    .courant   (courant_r),
    .coef      (coef_r),
    .res_count (rq_count),
    .res_push  (res_push),
    .res       (res_item)
  );

  // result queue doubles as the output register stage
  wbas_fifo #(
    .T     (wbas_pkg::out_item_t),
    .DEPTH (RQ_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_item),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty),
    .full    (rq_full),
    .count   (rq_count)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // credit scheme: a finished update always finds room in the result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !rq_full)
    else $error("result pushed into full result queue");

  // job enqueued only when the point itself was taken
  a_job_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    jq_push |-> (accept && !jq_full))
    else $error("job pushed without an accepted item");

  // points are refused only while the job queue is at capacity
  a_full_means_jq_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (jq_count == ($clog2(JQ_DEPTH+1))'(JQ_DEPTH)))
    else $error("input refused with room in the job queue");

  // end-of-row marker only on the index-0 result
  a_done_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.row_done) |-> (out_data.point_index == wbas_pkg::IDX_ZERO))
    else $error("row_done on a result other than index 0");

endmodule

// ===== hw/rtl/wbas_fifo.sv =====
// Small register-based queue with occupancy count.
module wbas_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  T                           wr_data,
  input  logic                       rd_en,
  output T                           rd_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  T               mem [DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [AW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign count   = cnt_r;
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/wbas_front.sv =====
// Front end: sliding point window, row position and job classification.
module wbas_front #(
  parameter int GRID_MAX = wbas_pkg::GRID_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  wbas_pkg::in_item_t in_data,
  output logic               jq_push,
  output wbas_pkg::job_t     job
);

  localparam int CNT_W = $clog2(GRID_MAX+1);
  typedef logic [CNT_W-1:0] cnt_t;

  cnt_t              cnt_r, cnt_nxt;
  wbas_pkg::sample_t prev_r, prev2_r, first_r, second_r;
  wbas_pkg::sample_t second_eff;
  logic              last, at_zero, at_one;

  assign at_zero    = (cnt_r == cnt_t'(0));
  assign at_one     = (cnt_r == cnt_t'(1));
  // an overlong row ends at GRID_MAX regardless of row_end
  assign last       = in_data.row_end | (cnt_r >= cnt_t'(GRID_MAX));
  assign second_eff = at_one ? in_data.sample : second_r;

  always_comb begin
    jq_push    = accept & ~at_zero & (~at_one | last);
    job.cur    = in_data.sample;
    job.prev   = prev_r;
    job.prev2  = prev2_r;
    job.first  = first_r;
    job.second = second_eff;
    job.idx    = wbas_pkg::idx_t'(cnt_r);
    if (at_one) begin
      job.kind = wbas_pkg::JOB_WRAP;
    end else if (last) begin
      job.kind = wbas_pkg::JOB_MAIN_WRAP;
    end else begin
      job.kind = wbas_pkg::JOB_MAIN;
    end
    cnt_nxt = last ? cnt_t'(0) : cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev2_r <= prev_r;
      prev_r  <= in_data.sample;
      if (at_zero) begin
        first_r <= in_data.sample;
      end
      if (at_one) begin
        second_r <= in_data.sample;
      end
    end
  end

endmodule

// ===== hw/rtl/wbas_back.sv =====
// Back end: job sequencer, three-stage difference/product/sum pipeline, rounding and saturation.
module wbas_back #(
  parameter int RQ_DEPTH = wbas_pkg::RQ_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wbas_pkg::job_t                job,
  input  logic                          job_empty,
  output logic                          job_pop,
  input  wbas_pkg::cn_t                 courant,
  input  wbas_pkg::coef_t               coef,
  input  logic [$clog2(RQ_DEPTH+1)-1:0] res_count,
  output logic                          res_push,
  output wbas_pkg::out_item_t           res
);

  localparam int SB      = wbas_pkg::SAMPLE_BITS;
  localparam int CQW     = $clog2(RQ_DEPTH+1);
  localparam int PKW     = wbas_pkg::COEF_W + SB + 2;
  localparam int NW      = PKW + 2;
  localparam int SHIFT_U = 2 * wbas_pkg::FRAC_BITS + 1;
  localparam int SHIFT_C = wbas_pkg::FRAC_BITS + 1;
  localparam int RW      = NW - SHIFT_U;

  typedef logic signed [SB:0]                    d1_t;
  typedef logic signed [SB+1:0]                  d2_t;
  typedef logic signed [wbas_pkg::CN_W+SB+1:0]   p1_t;
  typedef logic signed [PKW-1:0]                 pk_t;
  typedef logic signed [NW-1:0]                  n_t;

  localparam n_t ROUND_HALF = n_t'(1) <<< (SHIFT_U - 1);

  wbas_pkg::seq_state_t seq_r, seq_nxt;

  logic              issue, last_step, use_wrap, done;
  wbas_pkg::idx_t    idx;
  wbas_pkg::sample_t a0, a1, a2;
  logic [CQW+1:0]    occupancy;

  logic              s1_v_r, s2_v_r, s3_v_r;
  wbas_pkg::sample_t s1_u0_r, s2_u0_r;
  d1_t               s1_d1_r;
  d2_t               s1_d2_r;
  p1_t               s2_p1_r;
  pk_t               s2_pk_r;
  n_t                s3_n_r;
  wbas_pkg::idx_t    s1_idx_r, s2_idx_r, s3_idx_r;
  logic              s1_done_r, s2_done_r, s3_done_r;

  logic signed [wbas_pkg::CN_W:0] c_s;
  logic signed [RW-1:0]           r;
  logic [RW-SB:0]                 r_top;
  logic                           sat;

  // issue only with a guaranteed slot in the result queue
  assign occupancy = (CQW+2)'(res_count) + (CQW+2)'(s1_v_r) + (CQW+2)'(s2_v_r)
                   + (CQW+2)'(s3_v_r);
  assign issue     = ~job_empty & (occupancy < (CQW+2)'(RQ_DEPTH));
  assign job_pop   = issue & last_step;

  always_comb begin
    seq_nxt   = seq_r;
    use_wrap  = 1'b0;
    idx       = job.idx;
    done      = 1'b0;
    last_step = 1'b0;
    unique case (seq_r)
      wbas_pkg::SEQ_FIRST: begin
        use_wrap  = (job.kind == wbas_pkg::JOB_WRAP);
        idx       = use_wrap ? wbas_pkg::IDX_WRAP : job.idx;
        last_step = (job.kind == wbas_pkg::JOB_MAIN);
        if (issue) begin
          seq_nxt = last_step ? wbas_pkg::SEQ_FIRST : wbas_pkg::SEQ_SECOND;
        end
      end
      wbas_pkg::SEQ_SECOND: begin
        use_wrap = 1'b1;
        if (job.kind == wbas_pkg::JOB_WRAP) begin
          idx       = wbas_pkg::IDX_ZERO;
          done      = 1'b1;
          last_step = 1'b1;
        end else begin
          idx = wbas_pkg::IDX_WRAP;
        end
        if (issue) begin
          seq_nxt = last_step ? wbas_pkg::SEQ_FIRST : wbas_pkg::SEQ_THIRD;
        end
      end
      wbas_pkg::SEQ_THIRD: begin
        // index 0 repeats the last point's update
        idx       = wbas_pkg::IDX_ZERO;
        done      = 1'b1;
        last_step = 1'b1;
        if (issue) begin
          seq_nxt = wbas_pkg::SEQ_FIRST;
        end
      end
      default: begin
        seq_nxt = wbas_pkg::SEQ_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= wbas_pkg::SEQ_FIRST;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  // operand select: interior stencil or periodic wrap (u1, u0, u[n-2])
  always_comb begin
    if (use_wrap) begin
      a0 = job.second;
      a1 = job.first;
      a2 = job.prev;
    end else begin
      a0 = job.cur;
      a1 = job.prev;
      a2 = job.prev2;
    end
  end

  assign c_s = {1'b0, courant};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: first and second differences
    s1_u0_r   <= a0;
    s1_d1_r   <= d1_t'(a0) - d1_t'(a1);
    s1_d2_r   <= d2_t'(a0) - (d2_t'(a1) <<< 1) + d2_t'(a2);
    s1_idx_r  <= idx;
    s1_done_r <= done;
    // stage 2: products
    s2_u0_r   <= s1_u0_r;
    s2_p1_r   <= p1_t'(c_s) * p1_t'(s1_d1_r);
    s2_pk_r   <= pk_t'(coef) * pk_t'(s1_d2_r);
    s2_idx_r  <= s1_idx_r;
    s2_done_r <= s1_done_r;
    // stage 3: exact Q29 sum plus half for round-half-up
    s3_n_r    <= (n_t'(s2_u0_r) <<< SHIFT_U) - (n_t'(s2_p1_r) <<< SHIFT_C)
               - n_t'(s2_pk_r) + ROUND_HALF;
    s3_idx_r  <= s2_idx_r;
    s3_done_r <= s2_done_r;
  end

  assign r     = s3_n_r[NW-1:SHIFT_U];
  assign r_top = r[RW-1:SB-1];
  assign sat   = ~((&r_top) | ~(|r_top));

  always_comb begin
    res_push        = s3_v_r;
    res.point_index = s3_idx_r;
    res.row_done    = s3_done_r;
    res.saturated   = sat;
    if (!sat) begin
      res.new_value = r[SB-1:0];
    end else if (r[RW-1]) begin
      res.new_value = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res.new_value = {1'b0, {(SB-1){1'b1}}};
    end
  end

endmodule

// ===== bench/warming_beam_advection_step_tb.sv =====
// Self-checking testbench for the Warming-Beam advection step block.
module warming_beam_advection_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The uut runs with its default grid size; the predictor has to agree.
  localparam int GRID_PTS = wbas_pkg::GRID_MAX_DEF;
  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;
  localparam wbas_pkg::sample_t S_MAX = wbas_pkg::sample_t'(16'sh7fff);
  localparam wbas_pkg::sample_t S_MIN = wbas_pkg::sample_t'(16'sh8000);

  logic                          clk;
  logic                          rst_n;
  logic                          push;
  logic                          full;
  wbas_pkg::in_item_t            in_data;
  logic                          empty;
  logic                          pop;
  wbas_pkg::out_item_t           out_data;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [wbas_pkg::ADDR_W-1:0]   paddr;
  logic [wbas_pkg::DATA_W-1:0]   pwdata;
  logic [wbas_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  warming_beam_advection_step uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the Courant number, its c(1-c) product in
  // Q28, the three-point window and the position within the current row.
  // ---------------------------------------------------------------------------
  wbas_pkg::cn_t     courant_c;
  longint            courant_k;
  wbas_pkg::sample_t prev_pt;
  wbas_pkg::sample_t prev2_pt;
  wbas_pkg::sample_t first_pt;
  wbas_pkg::sample_t second_pt;
  int                pt_count;

  wbas_pkg::in_item_t  pending_points[$];   // items waiting to be pushed
  wbas_pkg::out_item_t expected_points[$];  // grid updates still owed by the uut

  int err_count;
  int items_in;
  int results_out;
  int rows_done;
  int clamped_seen;
  int settings_used;
  int burst_left;
  int gap_left;
  int stall_age;
  logic [15:0] stall_pattern;
  wbas_pkg::sample_t   walk_pt;     // random-walk source for smooth rows
  wbas_pkg::out_item_t want;

  // One Warming-Beam update, exact: value*2^29 = u0*2^29 - c*d1*2^15 - K*d2,
  // then rounded half up to a signed Q16.0 sample and clamped to the sample range.
  function automatic wbas_pkg::sample_t wb_point(input longint u0, input longint u1,
                                                 input longint u2, output logic sat);
    longint d1;
    longint d2;
    longint acc;
    longint r;
    d1  = u0 - u1;
    d2  = u0 - 2 * u1 + u2;
    acc = u0 * (64'sd1 <<< 29) - longint'(courant_c) * d1 * (64'sd1 <<< 15)
          - courant_k * d2 + (64'sd1 <<< 28);
    r   = acc >>> 29;
    sat = 1'b0;
    if (r > SMAX) begin
      r   = SMAX;
      sat = 1'b1;
    end
    if (r < SMIN) begin
      r   = SMIN;
      sat = 1'b1;
    end
    return wbas_pkg::sample_t'(r);
  endfunction

  // Advance the row by one accepted point and queue the results it produces.
  function automatic void advance_grid(input wbas_pkg::in_item_t pt);
    int                idx;
    logic              last;
    wbas_pkg::sample_t last_val;
    logic              last_sat;
    wbas_pkg::sample_t w;
    logic              wsat;
    idx      = pt_count;
    last     = pt.row_end;
    last_val = '0;
    last_sat = 1'b0;
    // a row may not outgrow the grid: the point at GRID_PTS closes it
    if (idx >= GRID_PTS) last = 1'b1;
    if (idx == 0) first_pt = pt.sample;
    else if (idx == 1) second_pt = pt.sample;
    else begin
      last_val = wb_point(pt.sample, prev_pt, prev2_pt, last_sat);
      expected_points.push_back(
        wbas_pkg::out_item_t'{last_val, wbas_pkg::idx_t'(idx), 1'b0, last_sat});
    end
    if (last) begin
      // a one-point row produces nothing; otherwise wrap for index 1, copy for 0
      if (idx >= 1) begin
        w = wb_point(second_pt, first_pt, prev_pt, wsat);
        expected_points.push_back(
          wbas_pkg::out_item_t'{w, wbas_pkg::IDX_WRAP, 1'b0, wsat});
        if (idx == 1) begin
          last_val = w;
          last_sat = wsat;
        end
        expected_points.push_back(
          wbas_pkg::out_item_t'{last_val, wbas_pkg::IDX_ZERO, 1'b1, last_sat});
      end
      pt_count = 0;
    end else begin
      pt_count = idx + 1;
    end
    prev2_pt = prev_pt;
    prev_pt  = pt.sample;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents the oldest pending item at the falling edge, in bursts of
  // random length. Half of the bursts are followed by no gap at all, so long
  // back-to-back stretches occur as well.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      push <= 1'b0;
    end else if (pending_points.size() == 0) begin
      push <= 1'b0;
    end else begin
      push    <= 1'b1;
      in_data <= pending_points[0];
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // Receiver: pop follows a rotating stall pattern, re-drawn whenever stall_age wraps;
  // a quarter of the patterns never stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      stall_age = stall_age + 1;
      if (stall_age >= 48) begin
        stall_age = 0;
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
        if (stall_pattern == 16'h0000) stall_pattern = 16'h0001;
      end
      pop <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge take note of an accepted item (prediction first,
  // so an expectation exists before its result could be checked) and compare an
  // accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        advance_grid(in_data);
        void'(pending_points.pop_front());
        items_in = items_in + 1;
      end
      if (pop && !empty) begin
        results_out = results_out + 1;
        if (out_data.saturated === 1'b1) clamped_seen = clamped_seen + 1;
        if (out_data.row_done === 1'b1) rows_done = rows_done + 1;
        if (expected_points.size() == 0) begin
          err_count = err_count + 1;
          if (err_count <= 10)
            $display("%0t: unexpected result value=%0d index=%0d done=%0b sat=%0b",
                     $realtime, out_data.new_value, out_data.point_index,
                     out_data.row_done, out_data.saturated);
        end else begin
          want = expected_points.pop_front();
          if (out_data.new_value !== want.new_value ||
              out_data.point_index !== want.point_index ||
              out_data.row_done !== want.row_done ||
              out_data.saturated !== want.saturated) begin
            err_count = err_count + 1;
            if (err_count <= 10)
              $display({"%0t: mismatch exp value=%0d index=%0d done=%0b sat=%0b,",
                        " got %0d %0d %0b %0b"},
                       $realtime, want.new_value, want.point_index, want.row_done,
                       want.saturated, out_data.new_value, out_data.point_index,
                       out_data.row_done, out_data.saturated);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration access: setup cycle, then access cycle until pready.
  // ---------------------------------------------------------------------------
  task automatic courant_write(input wbas_pkg::cn_t val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {wbas_pkg::REG_COURANT, 2'b00};
    // upper data bits are outside the register and carry noise
    pwdata  <= {16'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    courant_c = val;
    courant_k = longint'(val) * 16384 - longint'(val) * longint'(val);
    settings_used = settings_used + 1;
  endtask

  task automatic courant_check;
    logic [wbas_pkg::DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {wbas_pkg::REG_COURANT, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {16'h0000, courant_c}) begin
      err_count = err_count + 1;
      if (err_count <= 10)
        $display("%0t: courant readback exp %0d got %0d", $realtime, courant_c, got);
    end
  endtask

  // Wait until every queued item went in and every result came out, then give
  // the pipeline time to finish a row that produced nothing.
  task automatic drain;
    while (pending_points.size() != 0 || expected_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Next sample of a row: mostly a random walk, some noise, some full scale.
  function automatic wbas_pkg::sample_t next_sample;
    int pick;
    longint v;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      v = longint'(walk_pt) + $urandom_range(0, 4096) - 2048;
      if (v > SMAX) v = SMAX;
      if (v < SMIN) v = SMIN;
      walk_pt = wbas_pkg::sample_t'(v);
    end else if (pick < 85) begin
      walk_pt = wbas_pkg::sample_t'($urandom);
    end else begin
      walk_pt = ($urandom_range(0, 1) == 0) ? S_MAX : S_MIN;
    end
    return walk_pt;
  endfunction

  task automatic queue_row(input int len);
    for (int i = 0; i < len; i++)
      pending_points.push_back(wbas_pkg::in_item_t'{next_sample(), i == len - 1});
  endtask

  // A phase of well-formed rows: mostly a handful of points, some one- and
  // two-point rows, now and then a longer one.
  task automatic queue_rows(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(3, 12);
      else if (pick < 9) len = $urandom_range(1, 2);
      else len = $urandom_range(13, 40);
      queue_row(len);
      sent = sent + len;
    end
  endtask

  task automatic queue_fixed(input wbas_pkg::sample_t s, input logic row_end);
    pending_points.push_back(wbas_pkg::in_item_t'{s, row_end});
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    in_data = '0;
    pop     = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    err_count     = 0;
    items_in      = 0;
    results_out   = 0;
    rows_done     = 0;
    clamped_seen  = 0;
    settings_used = 1;
    burst_left    = 1;
    gap_left      = 0;
    stall_age     = 0;
    stall_pattern = 16'hffff;
    walk_pt       = '0;
    // predictor reset state: c = 0.5, empty window, start of row
    courant_c = wbas_pkg::CN_RESET;
    courant_k = 64'sd8192 * 64'sd8192;
    prev_pt   = '0;
    prev2_pt  = '0;
    first_pt  = '0;
    second_pt = '0;
    pt_count  = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the register, then directed rows at c = 0.5.
    courant_check();
    queue_fixed(S_MAX, 1'b1);                       // one point: no result
    queue_fixed(S_MIN, 1'b0);                       // two points: wrap only
    queue_fixed(S_MAX, 1'b1);
    queue_fixed(S_MAX, 1'b0);                       // alternating full scale
    queue_fixed(S_MIN, 1'b0);
    queue_fixed(S_MAX, 1'b0);
    queue_fixed(S_MIN, 1'b1);
    queue_fixed(16'sd0, 1'b0);
    queue_fixed(16'sd1, 1'b0);
    queue_fixed(-16'sd1, 1'b0);                     // rounding ties near zero
    queue_fixed(16'sd16384, 1'b0);
    queue_fixed(-16'sd16384, 1'b1);
    drain();

    // c = 0: pure copy; c = 2 (top of the stable range) and 0xffff: clamping.
    courant_write(wbas_pkg::cn_t'(0));
    courant_check();
    queue_fixed(S_MIN, 1'b0);
    queue_fixed(16'sd3, 1'b0);
    queue_fixed(S_MAX, 1'b1);
    drain();
    courant_write(wbas_pkg::cn_t'(32768));
    courant_check();
    queue_fixed(S_MAX, 1'b0);
    queue_fixed(S_MIN, 1'b0);
    queue_fixed(S_MAX, 1'b0);
    queue_fixed(S_MIN, 1'b1);
    drain();
    courant_write(wbas_pkg::cn_t'(16'hffff));
    courant_check();
    queue_fixed(S_MIN, 1'b0);
    queue_fixed(S_MAX, 1'b0);
    queue_fixed(S_MIN, 1'b1);
    queue_rows(30);
    drain();

    // Random rows under random Courant numbers, mostly in the stable range.
    for (int ph = 0; ph < 6; ph++) begin
      courant_write((ph == 5) ? wbas_pkg::cn_t'($urandom)
                              : wbas_pkg::cn_t'($urandom_range(0, 32768)));
      queue_rows(20);
      drain();
    end

    $display("Pushed %0d grid points; checked %0d updates over %0d rows, %0d of them clamped,",
             items_in, results_out, rows_done, clamped_seen);
    $display("under %0d Courant settings including 0, 2.0 and 0xffff, with stalls both sides.",
             settings_used);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", err_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
